@@ rtl/core/gda_pkg.sv @@
// Package with the constants, arctangent table and pipeline types of the gradient direction block.
`default_nettype none

package gda_pkg;

   localparam int GRAD_BITS       = 11;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_W         = 16;

   localparam int CORDIC_ITERS = 28;
   localparam int Z_FRAC       = 24;
   localparam int XY_SHIFT     = 40;
   localparam int XY_W         = GRAD_BITS + XY_SHIFT + 3;
   localparam int Z_W          = 32;
   localparam int RND_SHIFT    = Z_FRAC - ANGLE_FRAC_BITS;
   localparam int MAG_W        = 8 + ANGLE_FRAC_BITS;
   localparam int OUT_W        = (MAG_W + 1 > ANGLE_W) ? MAG_W + 1 : ANGLE_W;

   localparam logic signed [Z_W-1:0] Z_MAX    = Z_W'(90) <<< Z_FRAC;
   localparam logic signed [Z_W-1:0] Z_HALF   = Z_W'(1) <<< (RND_SHIFT - 1);
   localparam logic [MAG_W-1:0]      MAG_MAX  = MAG_W'(90) << ANGLE_FRAC_BITS;
   localparam logic signed [OUT_W-1:0] RIGHT  = OUT_W'(90) <<< ANGLE_FRAC_BITS;

   // atan(2^-i) in degrees, scaled by 2^24 and rounded to nearest.
   localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
      32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
      32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
      32'd29,        32'd14,        32'd7
   };

   // Flags that travel beside the rotation data.
   typedef struct packed {
      logic special;   // an axis case, the rotation result is not used
      logic rt_pos;    // axis case giving +90 degrees
      logic rt_neg;    // axis case giving -90 degrees
      logic neg;       // exactly one gradient negative
   } flag_type;

endpackage

`default_nettype wire

@@ rtl/core/gradient_direction_angle.sv @@
// Top level of the gradient direction block: a fully pipelined vectoring CORDIC.
//
// The block takes one pixel's horizontal and vertical gradient on req_grad_x and
// req_grad_y, and returns the edge direction atan(grad_y / grad_x), folded to the
// range -90 to +90 degrees, on rsp_angle in units of 1/256 degree.
// A transfer in is taken at each rising edge at which start is high and busy is
// low. Busy is never raised: the pipeline takes a new transfer in every cycle.
// Each result is shown on rsp_angle for exactly one cycle, marked by rsp_strobe,
// once its transfer has passed the whole pipeline. One register holds the
// gradient magnitudes, 28 registers hold one CORDIC micro-rotation each, one
// register holds the clamped and rounded magnitude angle and the last drives the
// outputs. The throughput is one transfer per cycle, set by the single rotation
// per stage. Results leave in the order the transfers came in.
// The receiver cannot hold results off, so nothing ever stalls.
// Synchronous reset clears every valid bit, so no strobe appears from data that
// was in flight; the data registers themselves are not reset.
// Axis cases bypass the rotation: a zero horizontal gradient gives +90, 0 or -90
// degrees by the sign of the vertical gradient, and a zero vertical gradient
// gives 0.
`default_nettype none

module gradient_direction_angle
   import gda_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  signed [GRAD_BITS-1:0] req_grad_x,
   input  wire  signed [GRAD_BITS-1:0] req_grad_y,
   output logic                        rsp_strobe,
   output logic signed [ANGLE_W-1:0]   rsp_angle
);

   // Pipeline registers: index k holds the data before micro-rotation k.
   logic                    valid_ff [0:CORDIC_ITERS];
   flag_type                flag_ff  [0:CORDIC_ITERS];
   logic signed [XY_W-1:0]  x_ff     [0:CORDIC_ITERS];
   logic signed [XY_W-1:0]  y_ff     [0:CORDIC_ITERS];
   logic signed [Z_W-1:0]   z_ff     [0:CORDIC_ITERS];

   logic                    rnd_valid_ff;
   flag_type                rnd_flag_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [MAG_W-1:0]        mag_in;
   logic signed [Z_W-1:0]   zc;
   logic signed [Z_W-1:0]   zr;

   logic                    rsp_strobe_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_in;
   logic signed [OUT_W-1:0] signed_mag;

   logic [GRAD_BITS-1:0]    mag_x;
   logic [GRAD_BITS-1:0]    mag_y;
   flag_type                flag_in;
   logic                    accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Entry stage: magnitudes and axis-case classification.
   always_comb begin
      mag_x = req_grad_x[GRAD_BITS-1] ? (~req_grad_x + 1'b1) : req_grad_x;
      mag_y = req_grad_y[GRAD_BITS-1] ? (~req_grad_y + 1'b1) : req_grad_y;
      flag_in.special = (req_grad_x == '0) | (req_grad_y == '0);
      flag_in.rt_pos  = (req_grad_x == '0) & ~req_grad_y[GRAD_BITS-1] & (req_grad_y != '0);
      flag_in.rt_neg  = (req_grad_x == '0) & req_grad_y[GRAD_BITS-1];
      flag_in.neg     = req_grad_x[GRAD_BITS-1] ^ req_grad_y[GRAD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
      end
      flag_ff[0] <= flag_in;
      x_ff[0]    <= XY_W'(mag_x) <<< XY_SHIFT;
      y_ff[0]    <= XY_W'(mag_y) <<< XY_SHIFT;
      z_ff[0]    <= '0;
   end

   // One micro-rotation per stage. The arithmetic shift of y rounds toward minus infinity, so a
   // negative y with bits shifted out gets one added back.
   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic                   corr;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;

      if (i == 0) begin : g_nocorr
         assign corr = 1'b0;
      end else begin : g_corr
         assign corr = y_ff[i][XY_W-1] & (|y_ff[i][i-1:0]);
      end

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!y_ff[i][XY_W-1]) begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + $signed(ATAN_TAB[i]);
         end else begin
            x_in = x_ff[i] - ys - XY_W'(corr);
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - $signed(ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         flag_ff[i+1] <= flag_ff[i];
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
      end
   end

   // Clamp the accumulated angle to [0, 90] degrees and round half up.
   always_comb begin
      if (z_ff[CORDIC_ITERS] < 0) begin
         zc = '0;
      end else if (z_ff[CORDIC_ITERS] > Z_MAX) begin
         zc = Z_MAX;
      end else begin
         zc = z_ff[CORDIC_ITERS];
      end
      zr     = zc + Z_HALF;
      mag_in = zr[RND_SHIFT +: MAG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= valid_ff[CORDIC_ITERS];
      end
      rnd_flag_ff <= flag_ff[CORDIC_ITERS];
      mag_ff      <= mag_in;
   end

   // Sign and axis-case selection; the result is cut to the port width.
   always_comb begin
      signed_mag = rnd_flag_ff.neg ? -$signed(OUT_W'(mag_ff)) : $signed(OUT_W'(mag_ff));
      if (rnd_flag_ff.special) begin
         if (rnd_flag_ff.rt_pos) begin
            rsp_angle_in = RIGHT[ANGLE_W-1:0];
         end else if (rnd_flag_ff.rt_neg) begin
            rsp_angle_in = ANGLE_W'(-RIGHT);
         end else begin
            rsp_angle_in = '0;
         end
      end else begin
         rsp_angle_in = signed_mag[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rnd_valid_ff;
      end
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_angle  = rsp_angle_ff;

   // The rounded magnitude never exceeds a right angle.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rnd_valid_ff |-> (mag_ff <= MAG_MAX))
      else $error("rounded angle magnitude above 90 degrees");

   // With both gradients nonzero the x component is positive after the last rotation.
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[CORDIC_ITERS] && !flag_ff[CORDIC_ITERS].special) |-> (x_ff[CORDIC_ITERS] > 0))
      else $error("CORDIC x component not positive");

   // A strobe follows a valid rounding stage in the next cycle, and nothing else.
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(rnd_valid_ff)))
      else $error("result strobe out of step with the pipeline");

   // The axis flags are exclusive and only occur for an axis case.
   a_axis_flags: assert property (@(posedge clock) disable iff (reset)
      rnd_valid_ff |-> ($onehot0({rnd_flag_ff.rt_pos, rnd_flag_ff.rt_neg}) &&
                        (rnd_flag_ff.special || !(rnd_flag_ff.rt_pos || rnd_flag_ff.rt_neg))))
      else $error("inconsistent axis-case flags");

endmodule

`default_nettype wire
